@@ hw/rtl/bvdp_pkg.sv @@
package bvdp_pkg;

	// Widths of the item fields
	localparam int unsigned BYTES_W  = 64;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned SUM_OUT_W = 32;
	localparam int unsigned LANE_MAX = 8;

	// Exact 9x9 signed product and the sum of up to eight of them
	localparam int unsigned EXT_W  = 9;
	localparam int unsigned PROD_W = 2 * EXT_W;
	localparam int unsigned SUM_W  = PROD_W + 3;

	// Reset value of the mode register: signed bytes
	localparam logic SIGNED_MODE_RST = 1'b1;

	// Control carried alongside the lane products
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

endpackage

@@ hw/rtl/bvdp_if.sv @@
interface bvdp_vec_if;
	logic                             valid;
	logic                             ready;
	logic [bvdp_pkg::BYTES_W-1:0]     a_bytes;
	logic [bvdp_pkg::BYTES_W-1:0]     b_bytes;
	logic [bvdp_pkg::COUNT_W-1:0]     lane_count;
	logic                             last_item;

	modport source (output valid, a_bytes, b_bytes, lane_count, last_item, input ready);
	modport sink   (input valid, a_bytes, b_bytes, lane_count, last_item, output ready);
endinterface

interface bvdp_sum_if;
	logic                             valid;
	logic                             ready;
	logic [bvdp_pkg::SUM_OUT_W-1:0]   dot_sum;

	modport source (output valid, dot_sum, input ready);
	modport sink   (input valid, dot_sum, output ready);
endinterface

@@ hw/rtl/bvdp_lane.sv @@
module bvdp_lane (
	input  logic                               clk,
	input  logic                               load,
	input  logic                               is_signed,
	input  logic                               active,
	input  logic [7:0]                         a_byte,
	input  logic [7:0]                         b_byte,
	output logic signed [bvdp_pkg::PROD_W-1:0] product_s1
);

	logic signed [bvdp_pkg::EXT_W-1:0]  a_ext;
	logic signed [bvdp_pkg::EXT_W-1:0]  b_ext;
	logic signed [bvdp_pkg::PROD_W-1:0] mul;

	// Widen each byte by one bit so both modes fit one signed multiplier
	assign a_ext = {is_signed & a_byte[7], a_byte};
	assign b_ext = {is_signed & b_byte[7], b_byte};
	assign mul   = a_ext * b_ext;

	// Capture the product; an inactive lane contributes zero
	always_ff @(posedge clk) begin
		if (load) begin
			product_s1 <= active ? mul : '0;
		end
	end

endmodule

@@ hw/rtl/bvdp_merge.sv @@
module bvdp_merge #(
	parameter int unsigned LANES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bvdp_pkg::stage_ctl_t               ctl_s1,
	input  logic signed [bvdp_pkg::PROD_W-1:0] product_s1 [LANES],
	output logic                               ready_s1,
	bvdp_sum_if.source                         result
);

	localparam int unsigned PAD_W = bvdp_pkg::SUM_OUT_W - bvdp_pkg::SUM_W;

	logic signed [bvdp_pkg::SUM_W-1:0]     tree_sum;
	logic signed [bvdp_pkg::SUM_W-1:0]     sum_s2;
	logic                                  valid_s2;
	logic                                  last_s2;
	logic [bvdp_pkg::SUM_OUT_W-1:0]        acc_q;
	logic [bvdp_pkg::SUM_OUT_W-1:0]        acc_next;
	logic [bvdp_pkg::SUM_OUT_W-1:0]        dot_sum_q;
	logic                                  out_valid_q;
	logic                                  out_free;
	logic                                  adv_s2;

	// Add the lane products
	always_comb begin
		tree_sum = '0;
		for (int k = 0; k < LANES; k++) begin
			tree_sum = tree_sum + bvdp_pkg::SUM_W'(product_s1[k]);
		end
	end

	// Stage two moves on unless it carries a last item and the output is full
	assign out_free = !out_valid_q || result.ready;
	assign adv_s2   = valid_s2 && (!last_s2 || out_free);
	assign ready_s1 = !valid_s2 || adv_s2;

	// Hold the lane sum for the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && ctl_s1.valid) begin
			sum_s2  <= tree_sum;
			last_s2 <= ctl_s1.last;
		end
	end

	assign acc_next = acc_q + {{PAD_W{sum_s2[bvdp_pkg::SUM_W-1]}}, sum_s2};

	// Accumulate; on the last item emit the total and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv_s2) begin
			acc_q <= last_s2 ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && last_s2) begin
			dot_sum_q <= acc_next;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.dot_sum = dot_sum_q;

`ifndef SYNTHESIS
	// The accumulator starts fresh after every emitted total
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && last_s2 |=> acc_q == '0)
		else $error("accumulator not cleared after last item");

	// A last item always lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && last_s2 |=> out_valid_q)
		else $error("total lost at output register");

	// No result appears without a last item
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q && !(adv_s2 && last_s2) |=> !out_valid_q)
		else $error("result without last item");

	// A blocked stage two keeps its sum
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv_s2 |=> valid_s2 && $stable(sum_s2) && $stable(acc_q))
		else $error("stalled stage two changed");
`endif

endmodule

@@ hw/rtl/byte_vector_dot_product.sv @@
// Streaming int8/uint8 dot product with a wrapping 32-bit accumulator. Each
// accepted item carries eight byte pairs; the first lane_count of them (capped
// at LANES) are multiplied exactly in parallel lanes, summed, and added to the
// running total. An item with last_item set produces one dot_sum result and
// clears the total; an empty vector gives 0. The block takes one item per
// clock: the lane multipliers and the single accumulator add each sit in a
// stage of their own, and a total is output once its last item has passed the
// product and sum registers. A result waiting at the output only stalls
// the input when another last item reaches the accumulator. signed_mode
// (reset 1) selects signed bytes; write it only while no vector is in flight.
module byte_vector_dot_product #(
	parameter int unsigned LANES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         signed_mode_we,
	input  logic         signed_mode_wdata,
	bvdp_vec_if.sink     vec,
	bvdp_sum_if.source   result
);

	localparam logic [bvdp_pkg::COUNT_W-1:0] LANES_CNT = bvdp_pkg::COUNT_W'(LANES);

	logic                               signed_mode_q;
	logic                               accept;
	logic                               ready_s1;
	logic                               ready_s2;
	logic                               valid_s1;
	logic                               last_s1;
	logic [bvdp_pkg::COUNT_W-1:0]       count_sat;
	logic [LANES-1:0]                   active;
	bvdp_pkg::stage_ctl_t               ctl_s1;
	logic signed [bvdp_pkg::PROD_W-1:0] product_s1 [LANES];

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= bvdp_pkg::SIGNED_MODE_RST;
		end else if (signed_mode_we) begin
			signed_mode_q <= signed_mode_wdata;
		end
	end

	// Stage one takes an item when empty or moving on
	assign ready_s1  = !valid_s1 || ready_s2;
	assign vec.ready = ready_s1;
	assign accept    = vec.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= vec.last_item;
		end
	end

	assign ctl_s1 = {valid_s1, last_s1};

	// Cap the lane count and mark the lanes that take part
	assign count_sat = (vec.lane_count > LANES_CNT) ? LANES_CNT : vec.lane_count;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			active[k] = bvdp_pkg::COUNT_W'(k) < count_sat;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bvdp_lane u_lane (
			.clk        (clk),
			.load       (accept),
			.is_signed  (signed_mode_q),
			.active     (active[g]),
			.a_byte     (vec.a_bytes[8*g +: 8]),
			.b_byte     (vec.b_bytes[8*g +: 8]),
			.product_s1 (product_s1[g])
		);
	end

	bvdp_merge #(
		.LANES (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.product_s1 (product_s1),
		.ready_s1   (ready_s2),
		.result     (result)
	);

endmodule

@@ test/byte_vector_dot_product_tb.sv @@
`timescale 1ns / 1ps

module byte_vector_dot_product_tb;

	typedef struct {
		logic [bvdp_pkg::BYTES_W-1:0] a_bytes;
		logic [bvdp_pkg::BYTES_W-1:0] b_bytes;
		logic [bvdp_pkg::COUNT_W-1:0] lane_count;
		logic                         last_item;
	} vec_item_t;

	logic clk;
	logic arst_n;
	logic signed_mode_we;
	logic signed_mode_wdata;

	bvdp_vec_if vec_ch ();
	bvdp_sum_if sum_ch ();

	byte_vector_dot_product #(
		.LANES(bvdp_pkg::LANE_MAX)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.signed_mode_we   (signed_mode_we),
		.signed_mode_wdata(signed_mode_wdata),
		.vec              (vec_ch),
		.result           (sum_ch)
	);

	// Items waiting for the driver; the head is the one on the bus
	vec_item_t pending_items[$];
	// Sums still owed by the block, oldest first
	logic [bvdp_pkg::SUM_OUT_W-1:0] expected_sums[$];

	logic [bvdp_pkg::SUM_OUT_W-1:0] sum_model;
	logic                           mode_model;
	logic                           item_taken;
	int unsigned                    fail_count;
	int unsigned                    random_items;

	// Sender and receiver pacing
	int unsigned send_style, send_style_left, gap_left, burst_left;
	int unsigned recv_style, recv_style_left, stall_left;

	// Sum of the lane products of one item, wrapped to 32 bits
	function automatic logic [bvdp_pkg::SUM_OUT_W-1:0] lane_products(
			input logic [bvdp_pkg::BYTES_W-1:0] a,
			input logic [bvdp_pkg::BYTES_W-1:0] b,
			input logic [bvdp_pkg::COUNT_W-1:0] count,
			input logic is_signed);
		logic [bvdp_pkg::SUM_OUT_W-1:0] total;
		int unsigned                    used;
		int                             x;
		int                             y;
		total = '0;
		used = (count > bvdp_pkg::LANE_MAX) ? bvdp_pkg::LANE_MAX : count;
		for (int k = 0; k < used; k++) begin
			x = is_signed ? int'($signed(a[8*k +: 8])) : int'(a[8*k +: 8]);
			y = is_signed ? int'($signed(b[8*k +: 8])) : int'(b[8*k +: 8]);
			total = total + bvdp_pkg::SUM_OUT_W'(x * y);
		end
		return total;
	endfunction

	// Random word, with lanes often forced to the byte extremes
	function automatic logic [bvdp_pkg::BYTES_W-1:0] rand_word();
		logic [bvdp_pkg::BYTES_W-1:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0) begin
			for (int k = 0; k < bvdp_pkg::LANE_MAX; k++) begin
				case ($urandom_range(0, 5))
					0: w[8*k +: 8] = 8'h00;
					1: w[8*k +: 8] = 8'hFF;
					2: w[8*k +: 8] = 8'h80;
					3: w[8*k +: 8] = 8'h7F;
					default: ;
				endcase
			end
		end
		return w;
	endfunction

	task automatic add_item(input logic [bvdp_pkg::BYTES_W-1:0] a,
			input logic [bvdp_pkg::BYTES_W-1:0] b,
			input int unsigned count, input logic last);
		vec_item_t it;
		it.a_bytes = a;
		it.b_bytes = b;
		it.lane_count = bvdp_pkg::COUNT_W'(count);
		it.last_item = last;
		pending_items.push_back(it);
	endtask

	// Queue one vector pair with random content and a random tail
	task automatic add_random_vector();
		int unsigned n_items;
		int unsigned count;
		n_items = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items - 1 || $urandom_range(0, 5) == 0)
				count = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			else
				count = bvdp_pkg::LANE_MAX;
			add_item(rand_word(), rand_word(), count, i == n_items - 1);
		end
		random_items += n_items;
	endtask

	// Wait until every item is taken, every sum is back and the pipeline is empty
	task automatic drain();
		while (pending_items.size() != 0 || expected_sums.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_signed_mode(input logic m);
		@(negedge clk);
		signed_mode_we <= 1'b1;
		signed_mode_wdata <= m;
		@(negedge clk);
		signed_mode_we <= 1'b0;
		mode_model = m;
	endtask

	task automatic note_failure(input string what,
			input logic [bvdp_pkg::SUM_OUT_W-1:0] want,
			input logic [bvdp_pkg::SUM_OUT_W-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Check results and predict from accepted items
	always @(posedge clk) begin
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= vec_ch.valid && vec_ch.ready;
			if (sum_ch.valid && sum_ch.ready) begin
				if (expected_sums.size() == 0)
					note_failure("dot_sum with nothing pending", '0, sum_ch.dot_sum);
				else if (expected_sums[0] != sum_ch.dot_sum)
					note_failure("dot_sum mismatch", expected_sums[0], sum_ch.dot_sum);
				if (expected_sums.size() != 0)
					void'(expected_sums.pop_front());
			end
			if (vec_ch.valid && vec_ch.ready) begin
				sum_model = sum_model + lane_products(vec_ch.a_bytes, vec_ch.b_bytes,
					vec_ch.lane_count, mode_model);
				if (vec_ch.last_item) begin
					expected_sums.push_back(sum_model);
					sum_model = '0;
				end
			end
		end
	end

	// Drive items in bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			vec_ch.valid <= 1'b0;
		end else begin
			if (item_taken)
				void'(pending_items.pop_front());
			if (send_style_left == 0) begin
				send_style = $urandom_range(0, 2);
				send_style_left = $urandom_range(50, 400);
			end else begin
				send_style_left--;
			end
			// Hold an item until it is taken
			if (!(vec_ch.valid && !item_taken)) begin
				if (gap_left > 0) begin
					gap_left--;
					vec_ch.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					vec_ch.a_bytes <= pending_items[0].a_bytes;
					vec_ch.b_bytes <= pending_items[0].b_bytes;
					vec_ch.lane_count <= pending_items[0].lane_count;
					vec_ch.last_item <= pending_items[0].last_item;
					vec_ch.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						case (send_style)
							0: begin
								gap_left = 0;
								burst_left = 64;
							end
							1: begin
								gap_left = $urandom_range(0, 2);
								burst_left = $urandom_range(1, 16);
							end
							default: begin
								gap_left = $urandom_range(1, 10);
								burst_left = $urandom_range(0, 3);
							end
						endcase
					end
				end else begin
					vec_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side on a pattern of its own
	always @(negedge clk) begin
		if (!arst_n) begin
			sum_ch.ready <= 1'b0;
		end else begin
			if (recv_style_left == 0) begin
				recv_style = $urandom_range(0, 2);
				recv_style_left = $urandom_range(30, 300);
			end else begin
				recv_style_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				sum_ch.ready <= 1'b0;
			end else begin
				case (recv_style)
					0: stall_left = 0;
					1: stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
					default: stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12) : 0;
				endcase
				sum_ch.ready <= (stall_left == 0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		signed_mode_we = 1'b0;
		signed_mode_wdata = 1'b0;
		vec_ch.valid = 1'b0;
		vec_ch.a_bytes = '0;
		vec_ch.b_bytes = '0;
		vec_ch.lane_count = '0;
		vec_ch.last_item = 1'b0;
		sum_ch.ready = 1'b0;
		item_taken = 1'b0;
		sum_model = '0;
		mode_model = bvdp_pkg::SIGNED_MODE_RST;
		fail_count = 0;
		random_items = 0;
		send_style = 0;
		send_style_left = 0;
		gap_left = 0;
		burst_left = 0;
		recv_style = 0;
		recv_style_left = 0;
		stall_left = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Signed extremes, empty and excess lane counts, multi-item vectors
		add_item({8{8'h80}}, {8{8'h80}}, 8, 1'b1);
		add_item({8{8'h7F}}, {8{8'h80}}, 8, 1'b1);
		add_item({8{8'hFF}}, {8{8'hFF}}, 8, 1'b1);
		add_item({8{8'h7F}}, {8{8'h7F}}, 8, 1'b1);
		add_item('0, '0, 8, 1'b1);
		add_item(rand_word(), rand_word(), 0, 1'b1);
		add_item(rand_word(), rand_word(), 15, 1'b1);
		add_item(rand_word(), rand_word(), 9, 1'b1);
		add_item(rand_word(), rand_word(), 0, 1'b0);
		add_item(rand_word(), rand_word(), 0, 1'b1);
		add_item(rand_word(), rand_word(), 8, 1'b0);
		add_item(rand_word(), rand_word(), 5, 1'b0);
		add_item(rand_word(), rand_word(), 1, 1'b1);
		for (int c = 1; c < bvdp_pkg::LANE_MAX; c++)
			add_item({8{8'hFF}}, {8{8'h81}}, c, 1'b1);
		drain();

		// Switch to unsigned in the middle of a vector
		add_item({8{8'hFF}}, {8{8'hFF}}, 8, 1'b0);
		drain();
		set_signed_mode(1'b0);
		add_item({8{8'hFF}}, {8{8'hFF}}, 1, 1'b1);
		add_item({8{8'hFF}}, {8{8'hFF}}, 8, 1'b1);
		add_item({8{8'h80}}, {8{8'h7F}}, 8, 1'b1);
		add_item(rand_word(), rand_word(), 0, 1'b1);
		drain();

		// Go negative in signed mode, then carry past 2^32 with unsigned products
		set_signed_mode(1'b1);
		add_item({8{8'h80}}, {8{8'h7F}}, 8, 1'b0);
		drain();
		set_signed_mode(1'b0);
		add_item({8{8'hFF}}, {8{8'hFF}}, 8, 1'b1);
		drain();

		// Random phases, unsigned in every third phase and signed in the others
		for (int p = 0; random_items < 1300; p++) begin
			set_signed_mode((p % 3 == 1) ? 1'b0 : 1'b1);
			while (pending_items.size() < 160)
				add_random_vector();
			drain();
		end

		if (fail_count == 0 && expected_sums.size() == 0)
			$display("byte_vector_dot_product_tb: done, clean");
		else
			$display("byte_vector_dot_product_tb: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("byte_vector_dot_product_tb: done, errors");
		$finish;
	end

endmodule
